>>> rtl/core/shld_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the sync word table for the sync/length deframer.
package shld_pkg;

	localparam logic [1:0] SYNC_FIRST   = 2'd0;
	localparam logic [1:0] SYNC_LAST    = 2'd3;
	localparam logic [8:0] LEN_INDEX    = 9'd10;
	localparam logic [8:0] LEN_BASE     = 9'd13;
	localparam logic [8:0] BODY_START   = 9'd4;

	typedef logic [7:0] byte_t;

	typedef enum logic [1:0] {
		REQ_NONE  = 2'd0,
		REQ_DATA  = 2'd1,
		REQ_BURST = 2'd2
	} req_kind_t;

	// One request from the parser to the output stage
	typedef struct packed {
		req_kind_t kind;
		byte_t     data;
		logic      last;
		logic      aborted;
	} req_t;

	function automatic byte_t sync_byte(input logic [1:0] idx);
		byte_t b;
		unique case (idx)
			2'd0: b = 8'h55;
			2'd1: b = 8'hAA;
			2'd2: b = 8'hCC;
			2'd3: b = 8'h33;
		endcase
		return b;
	endfunction

endpackage

>>> rtl/core/shld_parser.sv
`timescale 1ns / 1ps
// Input register, sync hunt and frame length tracking of the deframer.
module shld_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          cmd,
	input  logic [7:0]    data_byte,
	input  logic          out_free,
	output shld_pkg::req_t req
);
	import shld_pkg::*;

	logic       v_s1;
	logic       cmd_s1;
	byte_t      byte_s1;

	logic [1:0] sm_q, sm_n;
	logic [8:0] pos_q, pos_n;
	logic [8:0] len_q, len_n;
	logic       inf_q, inf_n;

	logic       adv;
	logic       hit;
	logic       last;
	logic [8:0] pos_inc;

	assign adv      = v_s1 & out_free;
	assign in_ready = ~v_s1 | out_free;
	assign hit      = (byte_s1 == sync_byte(sm_q));
	assign pos_inc  = pos_q + 9'd1;
	assign last     = (pos_q > LEN_INDEX) && (pos_inc == len_q);

	always_comb begin
		req   = '{kind: REQ_NONE, data: byte_s1, last: 1'b0, aborted: 1'b0};
		sm_n  = sm_q;
		pos_n = pos_q;
		len_n = len_q;
		inf_n = inf_q;
		if (cmd_s1) begin
			// clear: drop everything, flag an abort only inside a frame
			if (inf_q) begin
				req.kind    = REQ_DATA;
				req.data    = '0;
				req.aborted = 1'b1;
			end
			sm_n  = '0;
			pos_n = '0;
			len_n = '0;
			inf_n = 1'b0;
		end else if (inf_q) begin
			req.kind = REQ_DATA;
			req.last = last;
			if (pos_q == LEN_INDEX) begin
				len_n = LEN_BASE + {1'b0, byte_s1};
			end
			if (last) begin
				pos_n = '0;
				inf_n = 1'b0;
				sm_n  = '0;
			end else begin
				pos_n = pos_inc;
			end
		end else begin
			if (hit && sm_q == SYNC_LAST) begin
				req.kind = REQ_BURST;
				sm_n     = '0;
				inf_n    = 1'b1;
				pos_n    = BODY_START;
			end else if (hit) begin
				sm_n = sm_q + 2'd1;
			end else begin
				// slide by one byte: a failing 55 starts a new match
				sm_n = (byte_s1 == sync_byte(SYNC_FIRST)) ? 2'd1 : 2'd0;
			end
		end
		if (!v_s1) begin
			req.kind = REQ_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			cmd_s1 <= 1'b0;
			sm_q  <= '0;
			pos_q <= '0;
			len_q <= '0;
			inf_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (in_valid && in_ready) begin
				cmd_s1 <= cmd;
			end
			if (adv) begin
				sm_q  <= sm_n;
				pos_q <= pos_n;
				len_q <= len_n;
				inf_q <= inf_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
	end

endmodule

>>> rtl/core/shld_burst.sv
`timescale 1ns / 1ps
// Output register of the deframer; plays out the four-byte sync burst.
module shld_burst (
	input  logic           clk,
	input  logic           arst_n,
	input  shld_pkg::req_t req,
	output logic           out_free,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           first_of_frame,
	output logic           last_of_frame,
	output logic           aborted,
	output logic           end_of_burst
);
	import shld_pkg::*;

	logic       ov_s2;
	logic       burst_s2;
	logic [1:0] beat_s2;
	byte_t      data_s2;
	logic       last_s2;
	logic       abort_s2;
	logic       beat_last;
	logic       load;

	assign beat_last = ~burst_s2 | (beat_s2 == SYNC_LAST);
	assign out_free  = ~ov_s2 | (out_ready & beat_last);
	assign load      = out_free & (req.kind != REQ_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_s2    <= 1'b0;
			burst_s2 <= 1'b0;
			beat_s2  <= '0;
		end else if (out_free) begin
			ov_s2    <= (req.kind != REQ_NONE);
			burst_s2 <= (req.kind == REQ_BURST);
			beat_s2  <= '0;
		end else if (out_ready) begin
			// advance through the sync burst
			beat_s2 <= beat_s2 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s2  <= req.data;
			last_s2  <= req.last;
			abort_s2 <= req.aborted;
		end
	end

	assign out_valid      = ov_s2;
	assign out_byte       = burst_s2 ? sync_byte(beat_s2) : data_s2;
	assign first_of_frame = burst_s2 & (beat_s2 == SYNC_FIRST);
	assign last_of_frame  = ~burst_s2 & last_s2;
	assign aborted        = ~burst_s2 & abort_s2;
	assign end_of_burst   = beat_last;

endmodule

>>> rtl/core/sync_header_length_deframer_top.sv
`timescale 1ns / 1ps
// Top level of the sync word / length field deframer.
//
// Slave channel s_*: one request per received byte. s_tuser is the command
// (0 = data byte in s_tdata, 1 = clear and restart hunting).
// Master channel m_*: frame bytes in order, header included. m_tlast marks
// the byte at index length - 1, where length = 13 + byte at index 10.
// m_tuser flags the first sync byte, an abort and the end of the burst
// caused by one input request.
// Throughput: one byte per cycle while m_tready is high and no burst plays.
// A completed sync word gives four output beats; the input holds meanwhile.
// A clear inside a frame gives one beat with the abort flag and zero data.
// Each request passes the input register and then the output register
// before its first beat is valid on the master channel.
// Reset clears the hunt state, frame counters and both valid flags; the
// block then hunts for 55 AA CC 33. When the receiver stalls, the output
// register holds its beat and the input register absorbs one more request
// before s_tready drops.
module sync_header_length_deframer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tuser,   // [0] command
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,   // last_of_frame
	output logic [2:0] m_tuser    // [0] first_of_frame, [1] aborted, [2] end_of_burst
);
	import shld_pkg::*;

	req_t req;
	logic out_free;

	// hunt for the sync word and track the frame length
	shld_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.cmd       (s_tuser),
		.data_byte (s_tdata),
		.out_free  (out_free),
		.req       (req)
	);

	// hold each result until taken, expand the sync burst
	shld_burst u_burst (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.out_free       (out_free),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_byte       (m_tdata),
		.first_of_frame (m_tuser[0]),
		.last_of_frame  (m_tlast),
		.aborted        (m_tuser[1]),
		.end_of_burst   (m_tuser[2])
	);

endmodule

>>> rtl/core/shld_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the deframer and its bind to the top level.
module shld_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic [2:0] m_tuser
);

	// a stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled output beat changed");

	// the sync burst continues with AA right after its first byte
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser[0] |=> m_tvalid && m_tdata == 8'hAA
			&& !m_tuser[2] && !m_tuser[0])
		else $error("sync burst broken");

	// the first sync byte is always 55 and never ends a burst
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 8'h55 && !m_tuser[2] && !m_tlast)
		else $error("bad first-of-frame beat");

	// an abort carries zero data and closes its burst
	a_abort: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata == 8'h00 && m_tuser[2] && !m_tlast
			&& !m_tuser[0])
		else $error("bad abort beat");

endmodule

bind sync_header_length_deframer_top shld_chk u_shld_chk (.*);
